// File: hw/rtl/bcht_pkg.sv
`timescale 1ns / 1ps

package bcht_pkg;

    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int BKT_IN_W = 10;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RED,
        S_RD1,
        S_CK1,
        S_RD2,
        S_CK2,
        S_WRD,
        S_WCK,
        S_ULOG,
        S_URD,
        S_UWR,
        S_DONE
    } t_state;

endpackage

// File: hw/rtl/bcht_if.sv
`timescale 1ns / 1ps

interface bcht_req_if import bcht_pkg::*;;
    logic                valid;
    logic                ready;
    logic                mode;
    logic [KEY_W-1:0]    key;
    logic [BKT_IN_W-1:0] first_bucket;
    logic [BKT_IN_W-1:0] second_bucket;
    logic [HANDLE_W-1:0] new_handle;

    modport source (output valid, mode, key, first_bucket, second_bucket, new_handle,
                    input ready);
    modport sink   (input valid, mode, key, first_bucket, second_bucket, new_handle,
                    output ready);
endinterface

interface bcht_res_if import bcht_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, status, handle, input ready);
    modport sink   (input valid, status, handle, output ready);
endinterface

// File: hw/rtl/bcht_red.sv
`timescale 1ns / 1ps

module bcht_red import bcht_pkg::*; #(
    parameter int BUCKETS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [BKT_IN_W-1:0]        i_a,
    input  logic [BKT_IN_W-1:0]        i_b,
    output logic                       o_done,
    output logic [$clog2(BUCKETS)-1:0] o_a,
    output logic [$clog2(BUCKETS)-1:0] o_b
);

    localparam int IW   = $clog2(BUCKETS);
    localparam int SPAN = 1 << BKT_IN_W;
    // restoring steps needed so that the value ends below the bucket count
    localparam int RS   = (BUCKETS >= SPAN) ? 0 : $clog2((SPAN + BUCKETS - 1) / BUCKETS);
    localparam int CW   = (RS > 0) ? $clog2(RS + 1) : 1;
    localparam logic [BKT_IN_W:0] BK = (BKT_IN_W + 1)'(BUCKETS);

    logic                r_busy, n_busy;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [BKT_IN_W-1:0] r_a, n_a, r_b, n_b;
    logic [BKT_IN_W:0]   sub;

    assign sub = BK << (r_cnt - 1'b1);

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(RS);
            n_a    = i_a;
            n_b    = i_b;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_cnt = r_cnt - 1'b1;
                if ({1'b0, r_a} >= sub) n_a = BKT_IN_W'({1'b0, r_a} - sub);
                if ({1'b0, r_b} >= sub) n_b = BKT_IN_W'({1'b0, r_b} - sub);
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_a <= n_a;
        r_b <= n_b;
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_a    = IW'(r_a);
    assign o_b    = IW'(r_b);

endmodule

// File: hw/rtl/bcht_store.sv
`timescale 1ns / 1ps

module bcht_store #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4,
    parameter int EW      = 127
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [$clog2(BUCKETS)-1:0]  i_rd_addr,
    output logic [WAYS-1:0][EW-1:0]     o_rd_row,
    input  logic                        i_wr_en,
    input  logic [$clog2(BUCKETS)-1:0]  i_wr_addr,
    input  logic [WAYS-1:0]             i_wr_mask,
    input  logic [EW-1:0]               i_wr_entry
);

    // one row per bucket, written per way under a mask
    logic [WAYS-1:0][EW-1:0] r_mem [BUCKETS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            for (int w = 0; w < WAYS; w++) begin
                if (i_wr_mask[w]) r_mem[i_wr_addr][w] <= i_wr_entry;
            end
        end
        if (i_rd_en) o_rd_row <= r_mem[i_rd_addr];
    end

endmodule

// File: hw/rtl/bcht_cmp.sv
`timescale 1ns / 1ps

module bcht_cmp import bcht_pkg::*; #(
    parameter int WAYS = 4,
    parameter int IW   = 10
) (
    input  logic [WAYS-1:0][KEY_W+2*IW+HANDLE_W:0] i_row,
    input  logic [KEY_W-1:0]                       i_key,
    output logic                                   o_hit,
    output logic [HANDLE_W-1:0]                    o_hit_handle,
    output logic                                   o_free,
    output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] o_free_way
);

    localparam int EW    = KEY_W + 2 * IW + HANDLE_W + 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KEY_L = HANDLE_W + 2 * IW;

    // descending scan so the lowest way wins
    always_comb begin
        o_hit        = 1'b0;
        o_hit_handle = '0;
        o_free       = 1'b0;
        o_free_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_row[w][EW-1] && (i_row[w][KEY_L +: KEY_W] == i_key)) begin
                o_hit        = 1'b1;
                o_hit_handle = i_row[w][HANDLE_W-1:0];
            end
            if (!i_row[w][EW-1]) begin
                o_free     = 1'b1;
                o_free_way = WW'(w);
            end
        end
    end

endmodule

// File: hw/rtl/bucketed_cuckoo_hash_table.sv
`timescale 1ns / 1ps

// channel   dir  payload                                           transfer when
// i_req     in   mode, key, first_bucket, second_bucket, new_handle  valid & ready
// o_res     out  status, handle                                    valid & ready
//
// after reset a clearing pass runs over all BUCKETS rows, one row a cycle, ready low
// lookup: the bucket indices are reduced, then the first bucket row is read and checked,
//   and on a miss there the second; reduction takes R steps (zero at 1024 or more buckets);
//   an insert writes a free way of the first bucket, else walks from the second bucket
// each further displacement takes a row read, then a compare and write
// a failed walk rolls back each displacement with a log read, a row read and a write
// one request at a time; a result waits in its register while the next request runs

module bucketed_cuckoo_hash_table import bcht_pkg::*; #(
    parameter int BUCKETS   = 1024,
    parameter int WAYS      = 4,
    parameter int MAX_KICKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcht_req_if.sink    i_req,
    bcht_res_if.source  o_res
);

    localparam int IW    = $clog2(BUCKETS);
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int EW    = KEY_W + 2 * IW + HANDLE_W + 1;
    localparam int KCW   = $clog2(MAX_KICKS + 1);
    localparam int LW    = (MAX_KICKS > 1) ? $clog2(MAX_KICKS) : 1;
    // entry layout: valid, key, home_a, home_b, handle
    localparam int HB_L  = HANDLE_W;
    localparam int HA_L  = HANDLE_W + IW;

    t_state r_state, n_state;

    // request registers
    logic                r_mode;
    logic [KEY_W-1:0]    r_key;
    logic [HANDLE_W-1:0] r_nh;
    logic [IW-1:0]       r_fb, n_fb, r_sb, n_sb;

    // first bucket free way, kept across the second bucket read
    logic                r_free1, n_free1;
    logic [WW-1:0]       r_fway1, n_fway1;

    // walk state
    logic [EW-1:0]       r_carry, n_carry;
    logic [IW-1:0]       r_tgt, n_tgt;
    logic [KCW-1:0]      r_kick, n_kick;
    logic [WW-1:0]       r_kway, n_kway;
    logic [IW-1:0]       r_clr, n_clr;

    // undo log of displaced buckets, way follows from the step number
    logic [IW-1:0]       r_log [MAX_KICKS];
    logic [IW-1:0]       r_log_q;
    logic                log_we, log_re;
    logic [LW-1:0]       log_idx;

    // pending result and output register
    t_status             r_pst, n_pst;
    logic [HANDLE_W-1:0] r_phd, n_phd;
    logic                r_ovalid, n_ovalid;
    t_status             r_ost, n_ost;
    logic [HANDLE_W-1:0] r_ohd, n_ohd;

    // store and unit hookup
    logic                   rd_en, wr_en;
    logic [IW-1:0]          rd_addr, wr_addr;
    logic [WAYS-1:0]        wr_mask;
    logic [EW-1:0]          wr_entry;
    logic [WAYS-1:0][EW-1:0] rd_row;
    logic                   c_hit, c_free;
    logic [WW-1:0]          c_fway;
    logic [HANDLE_W-1:0]    c_hhd;
    logic                   red_start, red_done;
    logic [IW-1:0]          red_a, red_b;

    logic                   req_xfer, res_xfer, res_free;
    logic [EW-1:0]          new_entry, victim;
    logic [IW-1:0]          vict_other;
    logic [WW-1:0]          kway_inc, kway_dec;

    assign req_xfer   = i_req.valid && i_req.ready;
    assign res_xfer   = o_res.valid && o_res.ready;
    assign res_free   = !r_ovalid || o_res.ready;
    assign new_entry  = {1'b1, r_key, r_fb, r_sb, r_nh};
    assign victim     = rd_row[r_kway];
    // a victim moves on to its own other bucket
    assign vict_other = (victim[HA_L +: IW] == r_tgt) ? victim[HB_L +: IW]
                                                       : victim[HA_L +: IW];
    assign kway_inc   = (r_kway == WW'(WAYS - 1)) ? '0 : r_kway + 1'b1;
    assign kway_dec   = (r_kway == '0) ? WW'(WAYS - 1) : r_kway - 1'b1;

    bcht_red #(.BUCKETS(BUCKETS)) u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_a     (i_req.first_bucket),
        .i_b     (i_req.second_bucket),
        .o_done  (red_done),
        .o_a     (red_a),
        .o_b     (red_b)
    );

    bcht_store #(.BUCKETS(BUCKETS), .WAYS(WAYS), .EW(EW)) u_store (
        .i_clk      (i_clk),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_row   (rd_row),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_mask  (wr_mask),
        .i_wr_entry (wr_entry)
    );

    // shared bucket compare unit, fed by whatever row was last read
    bcht_cmp #(.WAYS(WAYS), .IW(IW)) u_cmp (
        .i_row        (rd_row),
        .i_key        (r_key),
        .o_hit        (c_hit),
        .o_hit_handle (c_hhd),
        .o_free       (c_free),
        .o_free_way   (c_fway)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == IW'(BUCKETS - 1)) n_state = S_IDLE;
            S_IDLE:  if (req_xfer) n_state = S_RED;
            S_RED:   if (red_done) n_state = S_RD1;
            S_RD1:   n_state = S_CK1;
            S_CK1:   n_state = c_hit ? S_DONE : S_RD2;
            S_RD2:   n_state = S_CK2;
            S_CK2: begin
                if (c_hit || !r_mode || r_free1) n_state = S_DONE;
                else n_state = S_WCK;
            end
            S_WRD:   n_state = S_WCK;
            S_WCK: begin
                if (c_free) n_state = S_DONE;
                else if (r_kick == KCW'(MAX_KICKS - 1)) n_state = S_ULOG;
                else n_state = S_WRD;
            end
            S_ULOG:  n_state = S_URD;
            S_URD:   n_state = S_UWR;
            S_UWR:   n_state = (r_kick == '0) ? S_DONE : S_ULOG;
            S_DONE:  if (res_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // control outputs
    always_comb begin
        i_req.ready = 1'b0;
        red_start   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_fb;
        wr_en       = 1'b0;
        wr_addr     = r_tgt;
        wr_mask     = '0;
        wr_entry    = r_carry;
        log_we      = 1'b0;
        log_re      = 1'b0;
        log_idx     = r_kick[LW-1:0];
        case (r_state)
            S_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = r_clr;
                wr_mask  = '1;
                wr_entry = '0;
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                red_start   = i_req.valid;
            end
            S_RD1: begin
                rd_en   = 1'b1;
                rd_addr = r_fb;
            end
            S_RD2: begin
                rd_en   = 1'b1;
                rd_addr = r_sb;
            end
            S_CK2: begin
                if (!c_hit && r_mode && r_free1) begin
                    wr_en    = 1'b1;
                    wr_addr  = r_fb;
                    wr_mask  = WAYS'(1) << r_fway1;
                    wr_entry = new_entry;
                end
            end
            S_WRD: begin
                rd_en   = 1'b1;
                rd_addr = r_tgt;
            end
            S_WCK: begin
                wr_en   = 1'b1;
                wr_addr = r_tgt;
                if (c_free) begin
                    wr_mask = WAYS'(1) << c_fway;
                end else begin
                    wr_mask = WAYS'(1) << r_kway;
                    log_we  = 1'b1;
                end
            end
            S_ULOG: begin
                log_re  = 1'b1;
                log_idx = LW'(r_kick - 1'b1);
            end
            S_URD: begin
                rd_en   = 1'b1;
                rd_addr = r_log_q;
            end
            S_UWR: begin
                wr_en   = 1'b1;
                wr_addr = r_log_q;
                wr_mask = WAYS'(1) << r_kway;
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_fb     = r_fb;
        n_sb     = r_sb;
        n_free1  = r_free1;
        n_fway1  = r_fway1;
        n_carry  = r_carry;
        n_tgt    = r_tgt;
        n_kick   = r_kick;
        n_kway   = r_kway;
        n_clr    = r_clr;
        n_pst    = r_pst;
        n_phd    = r_phd;
        n_ovalid = r_ovalid && !res_xfer;
        n_ost    = r_ost;
        n_ohd    = r_ohd;
        case (r_state)
            S_CLEAR: n_clr = r_clr + 1'b1;
            S_RED: begin
                n_fb = red_a;
                n_sb = red_b;
            end
            S_CK1: begin
                n_free1 = c_free;
                n_fway1 = c_fway;
                n_pst   = ST_FOUND;
                n_phd   = c_hhd;
            end
            S_CK2: begin
                n_pst = ST_FOUND;
                n_phd = c_hhd;
                if (!c_hit) begin
                    if (!r_mode) begin
                        n_pst = ST_NOTFOUND;
                        n_phd = '0;
                    end else if (r_free1) begin
                        n_pst = ST_INSERTED;
                        n_phd = r_nh;
                    end else begin
                        // walk starts at the second bucket, its row is still held
                        n_carry = new_entry;
                        n_tgt   = r_sb;
                        n_kick  = '0;
                        n_kway  = '0;
                    end
                end
            end
            S_WCK: begin
                if (c_free) begin
                    n_pst = ST_INSERTED;
                    n_phd = r_nh;
                end else begin
                    n_carry = victim;
                    n_tgt   = vict_other;
                    n_kick  = r_kick + 1'b1;
                    n_kway  = kway_inc;
                end
            end
            S_ULOG: begin
                n_kick = r_kick - 1'b1;
                n_kway = kway_dec;
            end
            S_UWR: begin
                n_carry = victim;
                n_pst   = ST_FULL;
                n_phd   = '0;
            end
            S_DONE: begin
                if (res_free) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_pst;
                    n_ohd    = r_phd;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_kick   <= '0;
            r_kway   <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_kick   <= n_kick;
            r_kway   <= n_kway;
        end
        if (req_xfer) begin
            r_mode <= i_req.mode;
            r_key  <= i_req.key;
            r_nh   <= i_req.new_handle;
        end
        r_fb    <= n_fb;
        r_sb    <= n_sb;
        r_free1 <= n_free1;
        r_fway1 <= n_fway1;
        r_carry <= n_carry;
        r_tgt   <= n_tgt;
        r_pst   <= n_pst;
        r_phd   <= n_phd;
        r_ost   <= n_ost;
        r_ohd   <= n_ohd;
    end

    // undo log memory
    always_ff @(posedge i_clk) begin
        if (log_we) r_log[log_idx] <= r_tgt;
        if (log_re) r_log_q <= r_log[log_idx];
    end

    assign o_res.valid  = r_ovalid;
    assign o_res.status = r_ost;
    assign o_res.handle = r_ohd;

`ifndef SYNTHESIS
    a_kick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kick <= KCW'(MAX_KICKS))
        else $error("displacement count past its bound");

    a_zero_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (r_ost == ST_FULL || r_ost == ST_NOTFOUND)) |-> (r_ohd == '0))
        else $error("non-zero handle on a miss or a full table");

    a_accept_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer |=> (r_state == S_RED))
        else $error("request taken outside idle");

    a_red_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD1) |-> (r_fb <= IW'(BUCKETS - 1) && r_sb <= IW'(BUCKETS - 1)))
        else $error("bucket index not reduced");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !res_free) |=> (r_state == S_DONE))
        else $error("result dropped while output busy");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bcht_pkg::*;

    localparam int BKTS   = 1024;
    localparam int NWAYS  = 4;
    localparam int KICKS  = 16;
    localparam int NSLOT  = BKTS * NWAYS;
    localparam int N_RAND = 1900;
    localparam int WDOG   = 20000;

    typedef struct packed {
        logic                mode;
        logic [KEY_W-1:0]    key;
        logic [BKT_IN_W-1:0] fb;
        logic [BKT_IN_W-1:0] sb;
        logic [HANDLE_W-1:0] nh;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] handle;
    } t_res;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [9:0]          ha;
        logic [9:0]          hb;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bcht_req_if req_if ();
    bcht_res_if res_if ();

    bucketed_cuckoo_hash_table #(.BUCKETS(BKTS), .WAYS(NWAYS), .MAX_KICKS(KICKS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always #4 i_clk = ~i_clk;

    // shadow copy of the table
    bit     tbl_valid [NSLOT];
    t_entry tbl_entry [NSLOT];

    t_req pending_reqs [$];
    t_res expected_res [$];
    int   n_errors = 0;
    int   idle_cycles = 0;
    bit   stim_done = 1'b0;
    bit   hold_off = 1'b0;

    // recent keys, for hits and collisions
    logic [KEY_W-1:0] key_pool [$];

    function automatic int find_key(int b, logic [KEY_W-1:0] k);
        for (int w = 0; w < NWAYS; w++)
            if (tbl_valid[b*NWAYS+w] && tbl_entry[b*NWAYS+w].key == k) return w;
        return NWAYS;
    endfunction

    function automatic int find_free(int b);
        for (int w = 0; w < NWAYS; w++)
            if (!tbl_valid[b*NWAYS+w]) return w;
        return NWAYS;
    endfunction

    // work out the result of one request and update the shadow table
    function automatic t_res predict_lookup_insert(t_req r);
        t_res   res;
        t_entry carry, victim;
        int     fb, sb, w, tgt, p;
        int     undo [KICKS];
        fb = r.fb % BKTS;
        sb = r.sb % BKTS;
        w = find_key(fb, r.key);
        if (w < NWAYS) return '{ST_FOUND, tbl_entry[fb*NWAYS+w].handle};
        w = find_key(sb, r.key);
        if (w < NWAYS) return '{ST_FOUND, tbl_entry[sb*NWAYS+w].handle};
        if (!r.mode) return '{ST_NOTFOUND, '0};
        carry = '{r.key, fb[9:0], sb[9:0], r.nh};
        w = find_free(fb);
        if (w < NWAYS) begin
            tbl_valid[fb*NWAYS+w] = 1'b1;
            tbl_entry[fb*NWAYS+w] = carry;
            return '{ST_INSERTED, r.nh};
        end
        tgt = sb;
        for (int l = 0; l < KICKS; l++) begin
            w = find_free(tgt);
            if (w < NWAYS) begin
                tbl_valid[tgt*NWAYS+w] = 1'b1;
                tbl_entry[tgt*NWAYS+w] = carry;
                return '{ST_INSERTED, r.nh};
            end
            p = tgt*NWAYS + (l % NWAYS);
            undo[l] = p;
            victim = tbl_entry[p];
            tbl_entry[p] = carry;
            carry = victim;
            tgt = (int'(victim.ha) == tgt) ? int'(victim.hb) : int'(victim.ha);
            tgt = tgt % BKTS;
        end
        // walk exhausted: unwind newest first
        for (int l = KICKS - 1; l >= 0; l--) begin
            victim = tbl_entry[undo[l]];
            tbl_entry[undo[l]] = carry;
            carry = victim;
        end
        res = '{ST_FULL, '0};
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(0, 2) == 0)
            return key_pool[$urandom_range(0, key_pool.size()-1)];
        return {$urandom, $urandom};
    endfunction

    // stimulus: directed extremes, then random traffic into a small hot region
    initial begin
        t_req r;
        logic [KEY_W-1:0] k;
        r = '{1'b0, '0, '0, '0, '0};
        pending_reqs.push_back(r);                              // lookup, empty table
        r = '{1'b1, '0, '0, '0, '0};
        pending_reqs.push_back(r);                              // insert zero key
        r = '{1'b1, '1, 10'h3ff, 10'h3ff, '1};
        pending_reqs.push_back(r);                              // all ones, equal buckets
        r = '{1'b1, '1, 10'h3ff, 10'h3ff, 32'h5};
        pending_reqs.push_back(r);                              // present key on insert
        r = '{1'b0, '1, 10'h0, 10'h3ff, '0};
        pending_reqs.push_back(r);                              // hit in second bucket
        // fill buckets 5 and 6, then overflow so the walk kicks and rolls back
        for (int i = 0; i < 12; i++) begin
            r = '{1'b1, 64'hA000 + i, 10'd5, 10'd6, 32'h100 + i};
            pending_reqs.push_back(r);
        end
        r = '{1'b0, 64'hA00B, 10'd5, 10'd6, '0};
        pending_reqs.push_back(r);
        r = '{1'b0, 64'hA003, 10'd6, 10'd5, '0};
        pending_reqs.push_back(r);
        // self-looping bucket overflows into rollback
        for (int i = 0; i < 6; i++) begin
            r = '{1'b1, 64'hB000 + i, 10'd9, 10'd9, 32'h200 + i};
            pending_reqs.push_back(r);
        end
        for (int i = 0; i < N_RAND; i++) begin
            k = pick_key();
            r.mode = ($urandom_range(0, 3) != 0);
            r.key  = k;
            if ($urandom_range(0, 9) == 0) begin
                r.fb = BKT_IN_W'($urandom);
                r.sb = BKT_IN_W'($urandom);
            end else begin
                // keep a key's buckets stable so hits are consistent
                r.fb = k[3:0] + 10'd16;
                r.sb = k[7:4] + 10'd16;
            end
            r.nh = $urandom;
            if (key_pool.size() < 200) key_pool.push_back(k);
            pending_reqs.push_back(r);
        end
        stim_done = 1'b1;
    end

    // request driver
    int gap_req = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.mode <= 1'b0;
            req_if.key <= '0;
            req_if.first_bucket <= '0;
            req_if.second_bucket <= '0;
            req_if.new_handle <= '0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid && req_if.ready)
                expected_res.push_back(predict_lookup_insert(
                    {req_if.mode, req_if.key, req_if.first_bucket,
                     req_if.second_bucket, req_if.new_handle}));
            if (gap_req > 0) begin
                gap_req <= gap_req - 1;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                t_req r;
                r = pending_reqs.pop_front();
                req_if.valid <= 1'b1;
                req_if.mode <= r.mode;
                req_if.key <= r.key;
                req_if.first_bucket <= r.fb;
                req_if.second_bucket <= r.sb;
                req_if.new_handle <= r.nh;
                gap_req <= ($urandom_range(0, 9) < 6) ? 0 :
                           ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 4);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        t_res exp_r;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_res.size() == 0) begin
                    $error("result transfer with nothing expected");
                    n_errors++;
                end else begin
                    exp_r = expected_res.pop_front();
                    if (res_if.status !== exp_r.status) begin
                        $error("status expected %0d actual %0d", exp_r.status, res_if.status);
                        n_errors++;
                    end
                    if (res_if.handle !== exp_r.handle) begin
                        $error("handle expected %h actual %h", exp_r.handle, res_if.handle);
                        n_errors++;
                    end
                end
            end
            if (hold_off) res_if.ready <= 1'b0;
            else if ($urandom_range(0, 19) == 0) res_if.ready <= 1'b0;
            else res_if.ready <= ($urandom_range(0, 9) < 8);
        end
    end

    // long receiver hold-off early in the random part
    initial begin
        wait (i_rst_n);
        wait (pending_reqs.size() < N_RAND - 100);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // watchdog on transfers
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG) begin
            $display("bucketed_cuckoo_hash_table: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && pending_reqs.size() == 0);
        @(posedge i_clk);
        while (req_if.valid || expected_res.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && expected_res.size() == 0)
            $display("bucketed_cuckoo_hash_table: match");
        else
            $display("bucketed_cuckoo_hash_table: mismatch");
        $finish;
    end

endmodule
